/* rtl/ovk_pkg.sv */
// ----------------------------------------------------------------------------
// ovk_pkg
// Shared types and constants for the overlay key chord trigger.
// ----------------------------------------------------------------------------
package ovk_pkg;

  localparam int NUM_CHORDS_DEF = 4;
  localparam int DIGIT_W        = 4;

  localparam logic [7:0]  KEY_F7         = 8'h40;
  localparam logic [31:0] RESET_DEBOUNCE = 32'd50000;
  localparam logic [31:0] RESET_HOLD     = 32'd2500000;
  localparam logic [31:0] RESET_FLASH    = 32'd3000000;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH    = 2'd2;

  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_USB  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] now_us;
    logic [7:0]  usb_keycode;
    logic        shift_held;
    logic        other_key_held;
    logic [3:0]  digit_keys;
    logic [31:0] mount_gen;
  } in_t;

  typedef struct packed {
    logic       shown;
    logic       pinned;
    logic [3:0] drive_cycle;
    logic       key_consumed;
  } out_t;

  typedef struct packed {
    logic [31:0] debounce_time;
    logic [31:0] hold_time;
    logic [31:0] flash_time;
  } cfg_t;

endpackage

/* rtl/ovk_cfg.sv */
// ----------------------------------------------------------------------------
// ovk_cfg
// Configuration registers: debounce, hold and flash times.
// ----------------------------------------------------------------------------
module ovk_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ovk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output ovk_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time <= ovk_pkg::RESET_DEBOUNCE;
      cfg.hold_time     <= ovk_pkg::RESET_HOLD;
      cfg.flash_time    <= ovk_pkg::RESET_FLASH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ovk_pkg::CFG_DEBOUNCE: cfg.debounce_time <= cfg_data;
        ovk_pkg::CFG_HOLD:     cfg.hold_time     <= cfg_data;
        ovk_pkg::CFG_FLASH:    cfg.flash_time    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ovk_core.sv */
// ----------------------------------------------------------------------------
// ovk_core
// Overlay state and per-request evaluation: pin toggle, flash window,
// shift long-press and debounced shift+digit chords.
// ----------------------------------------------------------------------------
module ovk_core #(
  parameter int NUM_CHORDS = ovk_pkg::NUM_CHORDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  ovk_pkg::in_t  item,
  input  ovk_pkg::cfg_t cfg,
  output ovk_pkg::out_t res
);

  logic        pin_flag,        pin_flag_next;
  logic [63:0] flash_end,       flash_end_next;
  logic [31:0] last_generation, last_generation_next;
  logic        generation_seen, generation_seen_next;
  logic        shift_previous,  shift_previous_next;
  logic        hold_armed,      hold_armed_next;
  logic        hold_done,       hold_done_next;
  logic [63:0] hold_start,      hold_start_next;

  logic [NUM_CHORDS-1:0] chord_last,   chord_last_next;
  logic [NUM_CHORDS-1:0] stable_level, stable_level_next;
  logic [63:0]           change_time      [NUM_CHORDS];
  logic [63:0]           change_time_next [NUM_CHORDS];
  logic [NUM_CHORDS-1:0] cycles;

  logic        scan;
  logic        consumed;
  logic [63:0] hold_diff;
  logic [63:0] flash_diff;
  logic [63:0] chord_diff [NUM_CHORDS];
  logic        raw        [NUM_CHORDS];

  assign scan = (item.cmd == ovk_pkg::CMD_SCAN);

  always_comb begin
    pin_flag_next        = pin_flag;
    flash_end_next       = flash_end;
    last_generation_next = last_generation;
    generation_seen_next = generation_seen;
    shift_previous_next  = shift_previous;
    hold_armed_next      = hold_armed;
    hold_done_next       = hold_done;
    hold_start_next      = hold_start;
    consumed             = 1'b0;

    if (!scan) begin
      if (item.usb_keycode == ovk_pkg::KEY_F7) begin
        pin_flag_next = !pin_flag;
        consumed      = 1'b1;
      end
    end else begin
      if (!generation_seen) begin
        last_generation_next = item.mount_gen;
        generation_seen_next = 1'b1;
      end else if (item.mount_gen != last_generation) begin
        last_generation_next = item.mount_gen;
        flash_end_next       = item.now_us + {32'd0, cfg.flash_time};
      end

      if (item.shift_held && !shift_previous) begin
        hold_armed_next = 1'b1;
        hold_done_next  = 1'b0;
        hold_start_next = item.now_us;
      end else if (!item.shift_held) begin
        hold_armed_next = 1'b0;
      end
      shift_previous_next = item.shift_held;
      if (item.other_key_held) hold_start_next = item.now_us;
    end

    hold_diff = item.now_us - hold_start_next;
    if (scan && hold_armed_next && !hold_done_next &&
        hold_diff >= {32'd0, cfg.hold_time}) begin
      hold_done_next = 1'b1;
      pin_flag_next  = !pin_flag;
    end
  end

  always_comb begin
    chord_last_next   = chord_last;
    stable_level_next = stable_level;
    cycles            = '0;
    for (int n = 0; n < NUM_CHORDS; n++) begin
      change_time_next[n] = change_time[n];
      raw[n]              = 1'b0;
      if (n < ovk_pkg::DIGIT_W) raw[n] = item.shift_held && item.digit_keys[n[1:0]];
      chord_diff[n] = item.now_us - change_time[n];
      if (scan && pin_flag_next) begin
        if (raw[n] != chord_last[n]) begin
          chord_last_next[n]  = raw[n];
          change_time_next[n] = item.now_us;
        end else if (chord_diff[n] >= {32'd0, cfg.debounce_time} &&
                     stable_level[n] != raw[n]) begin
          stable_level_next[n] = raw[n];
          cycles[n]            = raw[n];
        end
      end
    end
  end

  assign flash_diff = flash_end_next - item.now_us;

  always_comb begin
    res.shown        = pin_flag_next || (flash_diff != '0 && !flash_diff[63]);
    res.pinned       = pin_flag_next;
    res.key_consumed = consumed;
    res.drive_cycle  = '0;
    for (int i = 0; i < ovk_pkg::DIGIT_W; i++) begin
      if (i < NUM_CHORDS) res.drive_cycle[i] = cycles[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_flag        <= 1'b0;
      flash_end       <= '0;
      last_generation <= '0;
      generation_seen <= 1'b0;
      shift_previous  <= 1'b0;
      hold_armed      <= 1'b0;
      hold_done       <= 1'b0;
      hold_start      <= '0;
      chord_last      <= '0;
      stable_level    <= '0;
      for (int n = 0; n < NUM_CHORDS; n++) change_time[n] <= '0;
    end else if (step) begin
      pin_flag        <= pin_flag_next;
      flash_end       <= flash_end_next;
      last_generation <= last_generation_next;
      generation_seen <= generation_seen_next;
      shift_previous  <= shift_previous_next;
      hold_armed      <= hold_armed_next;
      hold_done       <= hold_done_next;
      hold_start      <= hold_start_next;
      chord_last      <= chord_last_next;
      stable_level    <= stable_level_next;
      for (int n = 0; n < NUM_CHORDS; n++) change_time[n] <= change_time_next[n];
    end
  end

endmodule

/* rtl/overlay_key_chord_trigger_top.sv */
// ----------------------------------------------------------------------------
// overlay_key_chord_trigger_top
// Overlay show/pin control with shift long-press and shift+digit chords.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------
//   in      | in_valid / in_ready  | in_data  (ovk_pkg::in_t)
//   out     | out_valid / out_ready| out_data (ovk_pkg::out_t)
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// One request per cycle sustained while results are taken. An accepted request
// is held in the input register and evaluated into the result register once
// that register is empty or its result is being taken.
// A stalled result holds the input register; in_ready stays high while the
// input register is empty or moves on.
// Synchronous reset clears all state and configuration to defaults.
// ----------------------------------------------------------------------------
module overlay_key_chord_trigger_top #(
  parameter int NUM_CHORDS = ovk_pkg::NUM_CHORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ovk_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ovk_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [ovk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  ovk_pkg::in_t  in_reg;
  logic          in_reg_valid;
  ovk_pkg::cfg_t cfg;
  ovk_pkg::out_t res;
  logic          step;

  assign step     = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || step;

  ovk_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ovk_core #(
    .NUM_CHORDS (NUM_CHORDS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_reg),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_ready) in_reg_valid <= in_valid;
      if (step) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (in_valid && in_ready) in_reg <= in_data;
    if (step) out_data <= res;
  end

endmodule

/* rtl/ovk_checker.sv */
// ----------------------------------------------------------------------------
// ovk_checker
// Port-level checks for the overlay key chord trigger, bound to the top.
// ----------------------------------------------------------------------------
module ovk_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input ovk_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input ovk_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while waiting");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_pin_shown: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pinned |-> out_data.shown)
    else $error("pinned overlay not shown");

  a_cycle_pinned: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_cycle != '0 |-> out_data.pinned && !out_data.key_consumed)
    else $error("drive cycle without pin or on keycode request");

endmodule

bind overlay_key_chord_trigger_top ovk_checker u_ovk_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/overlay_key_chord_trigger_top_test.sv */
// ----------------------------------------------------------------------------
// overlay_key_chord_trigger_top_test
// Self-checking bench for the overlay show/pin and chord trigger block.
//
// Requests come from a queue that the stimulus process fills in phases. A
// clocked driver sends them in random bursts. A clocked monitor checks each
// result against the oldest entry of a queue of predicted results. A
// behavioral model of the overlay state fills that queue as requests are
// accepted. Phases run the reset timing, short and zero timings, the widest
// timings and random timings. Registers change only while the block is idle.
// ----------------------------------------------------------------------------
module overlay_key_chord_trigger_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ovk_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_OFF_LEN = 150;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  ovk_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  ovk_pkg::out_t out_data;
  logic                          cfg_we    = 1'b0;
  logic [ovk_pkg::CFG_IDX_W-1:0] cfg_index = ovk_pkg::CFG_DEBOUNCE;
  logic [31:0]                   cfg_data  = '0;

  overlay_key_chord_trigger_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // overlay model state and timing registers
  logic [31:0] ovl_debounce, ovl_hold, ovl_flash;
  logic        ovl_pin;
  logic [63:0] ovl_flash_end;
  logic [31:0] ovl_gen_last;
  logic        ovl_gen_seen;
  logic        ovl_shift_prev, ovl_hold_armed, ovl_hold_fired;
  logic [63:0] ovl_hold_start;
  logic [ovk_pkg::NUM_CHORDS_DEF-1:0] ovl_chord_raw, ovl_chord_level;
  logic [63:0] ovl_chord_time [ovk_pkg::NUM_CHORDS_DEF];

  ovk_pkg::in_t  pending_reqs [$];
  ovk_pkg::out_t expected_results [$];

  int mismatch_count = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int pulse_count    = 0;
  int consumed_count = 0;
  int shown_count    = 0;

  // random walk for scan passes
  logic [63:0] walk_time;
  logic [31:0] walk_gen;
  logic        walk_shift;
  logic [3:0]  walk_digits;

  function automatic ovk_pkg::out_t predict_overlay(ovk_pkg::in_t r);
    ovk_pkg::out_t res;
    logic          raw;
    logic [63:0]   left;
    int            n;
    res = '0;
    if (r.cmd == ovk_pkg::CMD_USB) begin
      if (r.usb_keycode == ovk_pkg::KEY_F7) begin
        ovl_pin = ~ovl_pin;
        res.key_consumed = 1'b1;
      end
    end else begin
      if (!ovl_gen_seen) begin
        ovl_gen_last = r.mount_gen;
        ovl_gen_seen = 1'b1;
      end else if (r.mount_gen != ovl_gen_last) begin
        ovl_gen_last  = r.mount_gen;
        ovl_flash_end = r.now_us + 64'(ovl_flash);
      end
      if (r.shift_held && !ovl_shift_prev) begin
        ovl_hold_armed = 1'b1;
        ovl_hold_fired = 1'b0;
        ovl_hold_start = r.now_us;
      end else if (!r.shift_held) begin
        ovl_hold_armed = 1'b0;
      end
      ovl_shift_prev = r.shift_held;
      if (r.other_key_held) ovl_hold_start = r.now_us;
      if (ovl_hold_armed && !ovl_hold_fired &&
          (r.now_us - ovl_hold_start) >= 64'(ovl_hold)) begin
        ovl_hold_fired = 1'b1;
        ovl_pin = ~ovl_pin;
      end
      if (ovl_pin) begin
        for (n = 0; n < ovk_pkg::NUM_CHORDS_DEF; n++) begin
          raw = r.shift_held && r.digit_keys[n];
          if (raw != ovl_chord_raw[n]) begin
            ovl_chord_raw[n]  = raw;
            ovl_chord_time[n] = r.now_us;
          end else if ((r.now_us - ovl_chord_time[n]) >= 64'(ovl_debounce) &&
                       ovl_chord_level[n] != raw) begin
            ovl_chord_level[n] = raw;
            if (raw) res.drive_cycle[n] = 1'b1;
          end
        end
      end
    end
    left = ovl_flash_end - r.now_us;
    res.shown  = ovl_pin || (left != 64'd0 && !left[63]);
    res.pinned = ovl_pin;
    return res;
  endfunction

  function automatic void compare_field(string name, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic ovk_pkg::in_t scan_req(logic [63:0] t, logic sh, logic oth,
                                            logic [3:0] dig, logic [31:0] gen);
    ovk_pkg::in_t r;
    r.cmd            = ovk_pkg::CMD_SCAN;
    r.now_us         = t;
    r.usb_keycode    = 8'($urandom);
    r.shift_held     = sh;
    r.other_key_held = oth;
    r.digit_keys     = dig;
    r.mount_gen      = gen;
    return r;
  endfunction

  function automatic ovk_pkg::in_t key_req(logic [63:0] t, logic [7:0] key);
    ovk_pkg::in_t r;
    r.cmd            = ovk_pkg::CMD_USB;
    r.now_us         = t;
    r.usb_keycode    = key;
    r.shift_held     = 1'($urandom);
    r.other_key_held = 1'($urandom);
    r.digit_keys     = 4'($urandom);
    r.mount_gen      = $urandom;
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_results.push_back(predict_overlay(in_data));
        sent_count++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_data  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern plus occasional long hold-off
  logic [15:0] stall_pattern = '1;
  int pattern_age   = 0;
  int hold_off_left = 0;
  int drained       = 0;
  int next_hold_off = 350;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) drained++;
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready <= 1'b0;
      end else if (drained >= next_hold_off) begin
        hold_off_left = HOLD_OFF_LEN;
        next_hold_off += 500;
        out_ready <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
          pattern_age   = 48;
        end
        pattern_age--;
        out_ready     <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  // monitor
  always @(posedge clk) begin : result_check
    ovk_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("shown", 4'(want.shown), 4'(out_data.shown));
        compare_field("pinned", 4'(want.pinned), 4'(out_data.pinned));
        compare_field("drive_cycle", want.drive_cycle, out_data.drive_cycle);
        compare_field("key_consumed", 4'(want.key_consumed), 4'(out_data.key_consumed));
        checked_count++;
        if (want.drive_cycle != 4'd0) pulse_count++;
        if (want.key_consumed) consumed_count++;
        if (want.shown) shown_count++;
      end
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [ovk_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      ovk_pkg::CFG_DEBOUNCE: ovl_debounce = value;
      ovk_pkg::CFG_HOLD:     ovl_hold     = value;
      ovk_pkg::CFG_FLASH:    ovl_flash    = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int count, logic [63:0] unit);
    ovk_pkg::in_t r;
    int           roll;
    @(negedge clk);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        r.cmd            = 1'($urandom);
        r.now_us         = {$urandom, $urandom};
        r.usb_keycode    = 8'($urandom);
        r.shift_held     = 1'($urandom);
        r.other_key_held = 1'($urandom);
        r.digit_keys     = 4'($urandom);
        r.mount_gen      = $urandom;
        walk_time = r.now_us;
      end else if (roll < 12) begin
        walk_time += 64'($urandom_range(0, 40)) * unit;
        r = key_req(walk_time,
                    ($urandom_range(0, 1) == 0) ? ovk_pkg::KEY_F7 : 8'($urandom));
      end else begin
        walk_time += 64'($urandom_range(0, 40)) * unit;
        if ($urandom_range(0, 7) == 0) walk_shift = ~walk_shift;
        if ($urandom_range(0, 6) == 0) walk_digits = 4'($urandom);
        if ($urandom_range(0, 29) == 0)
          walk_gen = ($urandom_range(0, 1) == 0) ? walk_gen + 32'd1 : $urandom;
        r = scan_req(walk_time, walk_shift, $urandom_range(0, 15) == 0, walk_digits, walk_gen);
      end
      pending_reqs.push_back(r);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    logic [63:0]  t;
    ovk_pkg::in_t r;
    int           n;
    ovl_debounce    = ovk_pkg::RESET_DEBOUNCE;
    ovl_hold        = ovk_pkg::RESET_HOLD;
    ovl_flash       = ovk_pkg::RESET_FLASH;
    ovl_pin         = 1'b0;
    ovl_flash_end   = '0;
    ovl_gen_last    = '0;
    ovl_gen_seen    = 1'b0;
    ovl_shift_prev  = 1'b0;
    ovl_hold_armed  = 1'b0;
    ovl_hold_fired  = 1'b0;
    ovl_hold_start  = '0;
    ovl_chord_raw   = '0;
    ovl_chord_level = '0;
    for (n = 0; n < ovk_pkg::NUM_CHORDS_DEF; n++) ovl_chord_time[n] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset timing
    t = 64'd1_000_000;
    pending_reqs.push_back(scan_req(t, 1'b0, 1'b0, 4'h0, 32'd7));    // first pass: record only
    pending_reqs.push_back(key_req(t + 10, ovk_pkg::KEY_F7));
    pending_reqs.push_back(key_req(t + 20, 8'h41));
    pending_reqs.push_back(key_req(t + 30, ovk_pkg::KEY_F7));
    t += 100;
    pending_reqs.push_back(scan_req(t, 1'b0, 1'b0, 4'h0, 32'd8));    // flash opens
    pending_reqs.push_back(scan_req(t + ovk_pkg::RESET_FLASH - 1, 1'b0, 1'b0, 4'h0, 32'd8));
    t += ovk_pkg::RESET_FLASH;
    pending_reqs.push_back(scan_req(t, 1'b0, 1'b0, 4'h0, 32'd8));    // window just closed
    t += 1000;
    pending_reqs.push_back(scan_req(t, 1'b1, 1'b0, 4'h0, 32'd8));    // shift rises
    t += 1_000_000;
    pending_reqs.push_back(scan_req(t, 1'b1, 1'b1, 4'h0, 32'd8));    // other key restarts hold
    t += ovk_pkg::RESET_HOLD - 1;
    pending_reqs.push_back(scan_req(t, 1'b1, 1'b0, 4'h0, 32'd8));
    t += 1;
    pending_reqs.push_back(scan_req(t, 1'b1, 1'b0, 4'b0001, 32'd8)); // pin set, chords run
    t += ovk_pkg::RESET_DEBOUNCE;
    pending_reqs.push_back(scan_req(t, 1'b1, 1'b0, 4'b0001, 32'd8));
    t += 10;
    pending_reqs.push_back(scan_req(t, 1'b1, 1'b0, 4'b1111, 32'd8));
    t += ovk_pkg::RESET_DEBOUNCE - 1;
    pending_reqs.push_back(scan_req(t, 1'b1, 1'b0, 4'b1111, 32'd8));
    t += 1;
    pending_reqs.push_back(scan_req(t, 1'b1, 1'b0, 4'b1111, 32'd8));
    t += 10;
    pending_reqs.push_back(scan_req(t, 1'b1, 1'b0, 4'h0, 32'd8));
    t += 60000;
    pending_reqs.push_back(scan_req(t, 1'b1, 1'b0, 4'h0, 32'd8));    // falling edges: no pulse
    t += 10;
    pending_reqs.push_back(scan_req(t, 1'b0, 1'b1, 4'b1111, 32'd8)); // other key, not armed
    r = '1;
    r.cmd = ovk_pkg::CMD_USB;
    pending_reqs.push_back(r);
    r = '0;
    r.cmd = ovk_pkg::CMD_USB;
    pending_reqs.push_back(r);
    r = '1;
    r.cmd = ovk_pkg::CMD_SCAN;
    pending_reqs.push_back(r);                                       // flash end wraps
    pending_reqs.push_back(scan_req(64'd0, 1'b0, 1'b0, 4'h0, 32'd0));
    pending_reqs.push_back(key_req(64'd5, ovk_pkg::KEY_F7));
    wait_idle();

    walk_time   = 64'd0;
    walk_gen    = 32'd0;
    walk_shift  = 1'b0;
    walk_digits = 4'h0;

    run_phase(250, 64'd20000);

    write_reg(ovk_pkg::CFG_DEBOUNCE, 32'd3);
    write_reg(ovk_pkg::CFG_HOLD, 32'd40);
    write_reg(ovk_pkg::CFG_FLASH, 32'd60);
    run_phase(250, 64'd1);

    write_reg(ovk_pkg::CFG_DEBOUNCE, 32'd0);
    write_reg(ovk_pkg::CFG_HOLD, 32'd0);
    write_reg(ovk_pkg::CFG_FLASH, 32'd0);
    write_reg(CFG_UNUSED, $urandom);
    run_phase(200, 64'd1);

    write_reg(ovk_pkg::CFG_DEBOUNCE, 32'hFFFF_FFFF);
    write_reg(ovk_pkg::CFG_HOLD, 32'hFFFF_FFFF);
    write_reg(ovk_pkg::CFG_FLASH, 32'hFFFF_FFFF);
    run_phase(250, 64'd1 << 27);

    write_reg(ovk_pkg::CFG_DEBOUNCE, $urandom_range(0, 100));
    write_reg(ovk_pkg::CFG_HOLD, $urandom_range(0, 300));
    write_reg(ovk_pkg::CFG_FLASH, $urandom_range(0, 300));
    run_phase(300, 64'd4);

    repeat (10) @(posedge clk);
    $display("Sent %0d requests over five timing setups, checked %0d results.",
             sent_count, checked_count);
    $display("Saw %0d chord pulses, %0d F7 toggles, %0d results with overlay shown.",
             pulse_count, consumed_count, shown_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* overlay_key_chord_trigger_top.f */
rtl/ovk_pkg.sv
rtl/ovk_cfg.sv
rtl/ovk_core.sv
rtl/overlay_key_chord_trigger_top.sv
rtl/ovk_checker.sv
tb/overlay_key_chord_trigger_top_test.sv
